/* sv/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// framing phases
	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_SIZE_LF = 3'd1,
		PH_BODY    = 3'd2,
		PH_BODY_LF = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	// sticky error codes
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FRAME = 2'd1,
		ERR_LARGE = 2'd2
	} err_t;

	// configuration register indexes
	localparam logic [1:0] REG_MAX_BODY  = 2'd0;
	localparam logic [1:0] REG_MAX_CHUNK = 2'd1;

	localparam int ACC_W   = 25;
	localparam int LEN_W   = 24;
	localparam int TOTAL_W = 33;

	localparam logic [31:0] MAX_BODY_RST  = 32'd1048576;
	localparam logic [23:0] MAX_CHUNK_RST = 24'd8192;

	localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	// one result of the decoder
	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       chunk_done;
		logic       body_done;
		err_t       error_code;
	} result_t;

	// returns {is_hex, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd0;
		if (b >= CH_0 && b <= CH_9) begin
			d = b - CH_0;
			return {1'b1, d[3:0]};
		end
		if (b >= CH_LO_A && b <= CH_LO_F) begin
			d = b - CH_LO_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		if (b >= CH_UP_A && b <= CH_UP_F) begin
			d = b - CH_UP_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

/* sv/http_chunked_body_decoder_unit.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Decodes an HTTP/1.1 chunked body one byte per request.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one raw body byte (in_byte) per
//   request; a request is taken when in_valid is high and in_stall is low
//   output channel: out_valid / out_stall carry one result per input byte:
//   data_valid/data_byte for payload, chunk_done on the closing lf of a
//   chunk, body_done on the closing lf of the zero-size chunk, error_code
//   config channel: cfg_valid / cfg_ready, cfg_index 0 is max_body_size,
//   1 is max_chunk_size, other indexes are ignored; cfg_ready is always high
//   result: the result of a byte is registered into the output buffer when
//   the byte is taken; the framing state updates at that same edge
//   throughput: one byte per cycle while in_stall is low; the next-state logic
//   (hex accumulate, payload count, running-total add and compare) is combinational
//   stall: a two-entry output buffer (output register plus skid register)
//   keeps taking bytes while a result waits; in_stall rises only when both
//   entries are full and is a pure register output
//   reset: arst_n low clears the framing state, the sticky error, the
//   buffer and restores the register defaults (1048576 and 8192)
//   errors are sticky until reset; after them each byte answers only the code
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic        chunk_done,
	output logic        body_done,
	output logic [1:0]  error_code,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration registers
	logic [31:0]                  max_body_q;
	logic [hcbd_pkg::LEN_W-1:0]   max_chunk_q;

	// framing state
	hcbd_pkg::phase_t             phase_q, phase_d;
	logic [hcbd_pkg::ACC_W-1:0]   accum_q, accum_d;
	logic [hcbd_pkg::LEN_W-1:0]   left_q, left_d;
	logic [hcbd_pkg::LEN_W-1:0]   len_q, len_d;
	logic [hcbd_pkg::TOTAL_W-1:0] total_q, total_d;
	hcbd_pkg::err_t               err_q, err_d;

	// result buffer: output register plus skid entry
	hcbd_pkg::result_t            res_d, out_q, skid_q;
	logic                         out_valid_q, skid_valid_q;

	logic                         accept;
	logic                         out_free;
	logic [4:0]                   hex;
	logic [hcbd_pkg::ACC_W+3:0]   accum_shift;
	logic [hcbd_pkg::TOTAL_W:0]   total_sum;
	logic [hcbd_pkg::TOTAL_W-1:0] total_sat;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q  <= hcbd_pkg::MAX_BODY_RST;
			max_chunk_q <= hcbd_pkg::MAX_CHUNK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				hcbd_pkg::REG_MAX_BODY:  max_body_q  <= cfg_data;
				hcbd_pkg::REG_MAX_CHUNK: max_chunk_q <= cfg_data[hcbd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// next framing state and result of the byte on the input
	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		left_d  = left_q;
		len_d   = len_q;
		total_d = total_q;
		err_d   = err_q;
		res_d   = '0;

		hex         = hcbd_pkg::hex_digit(in_byte);
		accum_shift = {accum_q, hex[3:0]};
		// running total of completed chunks, saturating at 33 bits
		total_sum   = {1'b0, total_q} + {{(hcbd_pkg::TOTAL_W+1-hcbd_pkg::LEN_W){1'b0}}, len_q};
		total_sat   = total_sum[hcbd_pkg::TOTAL_W] ? hcbd_pkg::TOTAL_MAX
		                                           : total_sum[hcbd_pkg::TOTAL_W-1:0];

		if (err_q == hcbd_pkg::ERR_NONE) begin
			case (phase_q)
				hcbd_pkg::PH_SIZE: begin
					if (hex[4]) begin
						// saturate once any digit would shift out of the top
						if (accum_q[hcbd_pkg::ACC_W-1 -: 4] != 4'd0)
							accum_d = hcbd_pkg::ACC_MAX;
						else
							accum_d = accum_shift[hcbd_pkg::ACC_W-1:0];
					end else if (in_byte == hcbd_pkg::CH_CR) begin
						// empty size field leaves accum at zero
						if (accum_q > {1'b0, max_chunk_q}) begin
							err_d = hcbd_pkg::ERR_LARGE;
						end else begin
							left_d  = accum_q[hcbd_pkg::LEN_W-1:0];
							len_d   = accum_q[hcbd_pkg::LEN_W-1:0];
							phase_d = hcbd_pkg::PH_SIZE_LF;
						end
					end else begin
						err_d = hcbd_pkg::ERR_FRAME;
					end
				end
				hcbd_pkg::PH_SIZE_LF: begin
					if (in_byte == hcbd_pkg::CH_LF)
						phase_d = hcbd_pkg::PH_BODY;
					else
						err_d = hcbd_pkg::ERR_FRAME;
				end
				hcbd_pkg::PH_BODY: begin
					if (left_q != '0) begin
						res_d.data_valid = 1'b1;
						res_d.data_byte  = in_byte;
						left_d           = left_q - 1'b1;
					end else if (in_byte == hcbd_pkg::CH_CR) begin
						phase_d = hcbd_pkg::PH_BODY_LF;
					end else begin
						err_d = hcbd_pkg::ERR_FRAME;
					end
				end
				hcbd_pkg::PH_BODY_LF: begin
					if (in_byte != hcbd_pkg::CH_LF) begin
						err_d = hcbd_pkg::ERR_FRAME;
					end else begin
						total_d = total_sat;
						if (total_sat > {1'b0, max_body_q}) begin
							err_d = hcbd_pkg::ERR_LARGE;
						end else begin
							res_d.chunk_done = 1'b1;
							if (len_q == '0) begin
								res_d.body_done = 1'b1;
								phase_d         = hcbd_pkg::PH_DONE;
							end else begin
								phase_d = hcbd_pkg::PH_SIZE;
							end
							accum_d = '0;
							left_d  = '0;
							len_d   = '0;
						end
					end
				end
				default: ;  // body finished: bytes ignored
			endcase
		end
		res_d.error_code = err_d;
	end

	// framing state registers, updated per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_SIZE;
			accum_q <= '0;
			left_q  <= '0;
			len_q   <= '0;
			total_q <= '0;
			err_q   <= hcbd_pkg::ERR_NONE;
		end else if (accept) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			left_q  <= left_d;
			len_q   <= len_d;
			total_q <= total_d;
			err_q   <= err_d;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= accept;
			end else begin
				out_valid_q  <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (accept)
					skid_q <= res_d;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_valid = out_q.data_valid;
	assign data_byte  = out_q.data_byte;
	assign chunk_done = out_q.chunk_done;
	assign body_done  = out_q.body_done;
	assign error_code = out_q.error_code;

endmodule

/* sv/hcbd_checker.sv */
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        data_valid,
	input logic [7:0]  data_byte,
	input logic        chunk_done,
	input logic        body_done,
	input logic [1:0]  error_code
);

	// last nonzero error code seen on a delivered result
	logic [1:0] err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			err_seen_q <= hcbd_pkg::ERR_NONE;
		else if (out_valid && !out_stall && error_code != hcbd_pkg::ERR_NONE)
			err_seen_q <= error_code;
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({data_valid, data_byte,
			chunk_done, body_done, error_code}))
		else $error("stalled result changed");

	// an error sticks on every later result
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_seen_q != hcbd_pkg::ERR_NONE |-> error_code == err_seen_q)
		else $error("error code not sticky");

	// payload and chunk close are exclusive and error-free
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (data_valid || chunk_done) |->
			error_code == hcbd_pkg::ERR_NONE && !(data_valid && chunk_done))
		else $error("payload or chunk close with error");

	// body end only with a chunk close
	a_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && body_done |-> chunk_done && !data_valid)
		else $error("body done without chunk done");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (.*);

/* sim/chunked_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_decode_checker
// Watches the byte, result and register channels of the chunked body decoder,
// predicts the result of every byte taken and compares it field by field.
// ----------------------------------------------------------------------------
module chunked_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        data_valid,
	input  logic [7:0]  data_byte,
	input  logic        chunk_done,
	input  logic        body_done,
	input  logic [1:0]  error_code,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          outstanding
);

	// predicted framing state
	hcbd_pkg::phase_t                     ph;
	logic [hcbd_pkg::ACC_W-1:0]   size_acc;
	logic [hcbd_pkg::LEN_W-1:0]   left_cnt;
	logic [hcbd_pkg::LEN_W-1:0]   cur_len;
	logic [hcbd_pkg::TOTAL_W-1:0] body_sum;
	hcbd_pkg::err_t               err_q;
	logic [31:0]                  body_limit;
	logic [23:0]                  chunk_limit;

	hcbd_pkg::result_t predicted_results[$];
	hcbd_pkg::result_t want;
	hcbd_pkg::result_t next_res;
	int                errs;

	function automatic int hex_nibble(input logic [7:0] b);
		if (b >= hcbd_pkg::CH_0 && b <= hcbd_pkg::CH_9)
			return int'(b - hcbd_pkg::CH_0);
		if (b >= hcbd_pkg::CH_LO_A && b <= hcbd_pkg::CH_LO_F)
			return int'(b - hcbd_pkg::CH_LO_A) + 10;
		if (b >= hcbd_pkg::CH_UP_A && b <= hcbd_pkg::CH_UP_F)
			return int'(b - hcbd_pkg::CH_UP_A) + 10;
		return -1;
	endfunction

	task automatic decode_byte(input logic [7:0] b, output hcbd_pkg::result_t r);
		int                         nib;
		logic [hcbd_pkg::ACC_W+3:0] shifted;
		logic [hcbd_pkg::TOTAL_W:0] sum;
		r = '0;
		nib = hex_nibble(b);
		if (err_q == hcbd_pkg::ERR_NONE) begin
			case (ph)
				hcbd_pkg::PH_SIZE: begin
					if (nib >= 0) begin
						shifted = {size_acc, 4'(nib)};
						size_acc = (shifted > hcbd_pkg::ACC_MAX) ? hcbd_pkg::ACC_MAX
						                                         : shifted[hcbd_pkg::ACC_W-1:0];
					end else if (b == hcbd_pkg::CH_CR) begin
						if (size_acc > chunk_limit) begin
							err_q = hcbd_pkg::ERR_LARGE;
						end else begin
							left_cnt = size_acc[hcbd_pkg::LEN_W-1:0];
							cur_len = size_acc[hcbd_pkg::LEN_W-1:0];
							ph = hcbd_pkg::PH_SIZE_LF;
						end
					end else begin
						err_q = hcbd_pkg::ERR_FRAME;
					end
				end
				hcbd_pkg::PH_SIZE_LF: begin
					if (b == hcbd_pkg::CH_LF)
						ph = hcbd_pkg::PH_BODY;
					else
						err_q = hcbd_pkg::ERR_FRAME;
				end
				hcbd_pkg::PH_BODY: begin
					if (left_cnt != 0) begin
						r.data_valid = 1'b1;
						r.data_byte = b;
						left_cnt = left_cnt - 1'b1;
					end else if (b == hcbd_pkg::CH_CR) begin
						ph = hcbd_pkg::PH_BODY_LF;
					end else begin
						err_q = hcbd_pkg::ERR_FRAME;
					end
				end
				hcbd_pkg::PH_BODY_LF: begin
					if (b != hcbd_pkg::CH_LF) begin
						err_q = hcbd_pkg::ERR_FRAME;
					end else begin
						sum = body_sum + cur_len;
						body_sum = (sum > hcbd_pkg::TOTAL_MAX) ? hcbd_pkg::TOTAL_MAX
						                                        : sum[hcbd_pkg::TOTAL_W-1:0];
						if (body_sum > body_limit) begin
							err_q = hcbd_pkg::ERR_LARGE;
						end else begin
							r.chunk_done = 1'b1;
							if (cur_len == 0) begin
								r.body_done = 1'b1;
								ph = hcbd_pkg::PH_DONE;
							end else begin
								ph = hcbd_pkg::PH_SIZE;
							end
							size_acc = '0;
							left_cnt = '0;
							cur_len = '0;
						end
					end
				end
				default: ;
			endcase
		end
		r.error_code = err_q;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = hcbd_pkg::PH_SIZE;
			size_acc = '0;
			left_cnt = '0;
			cur_len = '0;
			body_sum = '0;
			err_q = hcbd_pkg::ERR_NONE;
			body_limit = hcbd_pkg::MAX_BODY_RST;
			chunk_limit = hcbd_pkg::MAX_CHUNK_RST;
			predicted_results.delete();
			errs = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hcbd_pkg::REG_MAX_BODY: body_limit = cfg_data;
					hcbd_pkg::REG_MAX_CHUNK: chunk_limit = cfg_data[23:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$error("result with no request waiting");
					errs++;
				end else begin
					want = predicted_results.pop_front();
					check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
					check_field("data_byte", want.data_byte, data_byte);
					check_field("chunk_done", 8'(want.chunk_done), 8'(chunk_done));
					check_field("body_done", 8'(want.body_done), 8'(body_done));
					check_field("error_code", 8'(want.error_code), 8'(error_code));
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_byte, next_res);
				// append at the tail, results leave in request order
				predicted_results.insert(predicted_results.size(), next_res);
			end
			fail_count <= errs;
			outstanding <= predicted_results.size();
		end
	end

endmodule

/* sim/tb_http_chunked_body_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_unit
// Feeds one long chunked body through the decoder: a few hand-made chunks,
// then random well-formed chunks under several limit settings and traffic
// patterns, and finally one randomly chosen way of ending the body (normal
// end or one of the framing and size faults) followed by ignored bytes.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_unit;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 600000;

	// indexes past the last register, writes there must change nothing
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	// ways the body is closed at the end of the run
	typedef enum int {
		END_ZERO,
		END_EMPTY,
		END_BODY_EXACT,
		END_BODY_OVER,
		END_CHUNK_OVER,
		END_HUGE,
		END_BAD_DIGIT,
		END_NO_LF_SIZE,
		END_NO_LF_BODY,
		END_NO_CR_BODY
	} ending_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic        chunk_done;
	logic        body_done;
	logic [1:0]  error_code;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int fail_count;
	int outstanding;

	// traffic knobs, percent of cycles spent idle or stalled
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long hold-off of the receiver, requested by bumping hold_seq
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// payload bytes of all chunks sent complete, used to place body limits
	longint unsigned body_total = 0;
	int              items_sent = 0;
	int              cycle_count = 0;
	ending_t         ending;

	http_chunked_body_decoder_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_valid (data_valid),
		.data_byte  (data_byte),
		.chunk_done (chunk_done),
		.body_done  (body_done),
		.error_code (error_code),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	chunked_decode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_valid  (data_valid),
		.data_byte   (data_byte),
		.chunk_done  (chunk_done),
		.body_done   (body_done),
		.error_code  (error_code),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog, far above the slowest legal run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("http_chunked_body_decoder_unit: mismatch");
		$finish;
	end

	// receiver side: random stalls, or a long hold-off when one is requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
			end
		end
	end

	// one byte request: optional idle gap, then hold the byte until taken
	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		// in_stall is a register, this still reads its value at the edge
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, let every result drain, then idle quietly
	task automatic settle();
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// hex digit with random letter case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return hcbd_pkg::CH_0 + {4'd0, n};
		if ($urandom_range(0, 1))
			return hcbd_pkg::CH_LO_A + {4'd0, n} - 8'd10;
		return hcbd_pkg::CH_UP_A + {4'd0, n} - 8'd10;
	endfunction

	task automatic send_hex(input logic [23:0] v, input int zeros);
		int nd;
		int i;
		repeat (zeros) send_byte(hcbd_pkg::CH_0);
		nd = 1;
		while (nd < 6 && (v >> (4 * nd)) != 0)
			nd++;
		for (i = nd - 1; i >= 0; i--)
			send_byte(hex_char(v[4*i +: 4]));
	endtask

	// size field, sometimes with leading zeros, then cr lf
	task automatic send_head(input int len);
		send_hex(24'(len), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
	endtask

	// payload leans on cr, lf and the byte extremes
	task automatic send_payload(input int len);
		logic [7:0] b;
		repeat (len) begin
			case ($urandom_range(0, 9))
				0: b = hcbd_pkg::CH_CR;
				1: b = hcbd_pkg::CH_LF;
				2: b = 8'h00;
				3: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b);
		end
	endtask

	task automatic send_chunk(input int len);
		send_head(len);
		send_payload(len);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		body_total += len;
	endtask

	// well-formed nonzero chunks until the byte budget is spent
	task automatic run_chunks(input int budget, input int max_len);
		int first;
		int len;
		first = items_sent;
		while (items_sent - first < budget) begin
			// size right at the chunk limit now and then
			len = ($urandom_range(0, 7) == 0) ? max_len : $urandom_range(1, max_len);
			send_chunk(len);
		end
	endtask

	initial begin
		int         len;
		int         lim;
		logic [7:0] b;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= hcbd_pkg::REG_MAX_BODY;
		cfg_data <= 32'h0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// limits wide open, spare indexes poked, top byte of chunk limit junk
		write_reg(hcbd_pkg::REG_MAX_BODY, 32'hFFFF_FFFF);
		write_reg(hcbd_pkg::REG_MAX_CHUNK, {8'($urandom), 24'hFF_FFFF});
		write_reg(REG_SPARE_2, $urandom);
		write_reg(REG_SPARE_3, 32'h0);

		// hand-made chunks: one byte of 00, a cr inside a payload sized with
		// leading zeros, and a lone lf as payload
		send_byte(hex_char(4'd1));
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(8'h00);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(hcbd_pkg::CH_0);
		send_byte(hcbd_pkg::CH_0);
		send_byte(hex_char(4'd2));
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(8'hFF);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(hex_char(4'd1));
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(hcbd_pkg::CH_LF);
		send_byte(hcbd_pkg::CH_CR);
		send_byte(hcbd_pkg::CH_LF);
		body_total += 4;

		// no idling; the receiver holds off while bytes keep coming, so the
		// output buffer fills and the input stalls
		hold_seq++;
		run_chunks(140, 24);
		settle();

		// small chunk limit, sender mostly idle
		lim = $urandom_range(4, 32);
		write_reg(hcbd_pkg::REG_MAX_CHUNK, {8'($urandom), 24'(lim)});
		write_reg(hcbd_pkg::REG_MAX_BODY,
			32'(body_total) + 32'd1000 + $urandom_range(0, 1 << 20));
		send_idle_pct = 86;
		recv_stall_pct = 0;
		run_chunks(145, lim);
		settle();

		// tighter limits, receiver mostly stalled
		lim = $urandom_range(1, 16);
		write_reg(hcbd_pkg::REG_MAX_CHUNK, {8'($urandom), 24'(lim)});
		write_reg(hcbd_pkg::REG_MAX_BODY, 32'(body_total) + 32'd600);
		send_idle_pct = 0;
		recv_stall_pct = 86;
		run_chunks(145, lim);
		settle();

		// near-top chunk limit, both sides idling now and then
		write_reg(hcbd_pkg::REG_MAX_CHUNK,
			{8'($urandom), 24'hFF_FF00 | 24'($urandom_range(0, 255))});
		write_reg(hcbd_pkg::REG_MAX_BODY, 32'hFFFF_FFFF);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		run_chunks(145, 40);
		settle();

		// close the body one way; the error or end is final for this run
		send_idle_pct = 27;
		recv_stall_pct = 27;
		ending = ending_t'($urandom_range(0, 9));
		len = $urandom_range(1, 12);
		case (ending)
			END_ZERO: begin
				send_hex(24'd0, $urandom_range(0, 2));
				send_byte(hcbd_pkg::CH_CR);
				send_byte(hcbd_pkg::CH_LF);
				send_byte(hcbd_pkg::CH_CR);
				send_byte(hcbd_pkg::CH_LF);
			end
			END_EMPTY: begin
				// no size digits at all reads as size zero
				send_byte(hcbd_pkg::CH_CR);
				send_byte(hcbd_pkg::CH_LF);
				send_byte(hcbd_pkg::CH_CR);
				send_byte(hcbd_pkg::CH_LF);
			end
			END_BODY_EXACT: begin
				// total lands exactly on the body limit, still legal
				write_reg(hcbd_pkg::REG_MAX_BODY, 32'(body_total) + 32'(len));
				send_chunk(len);
				send_byte(hcbd_pkg::CH_0);
				send_byte(hcbd_pkg::CH_CR);
				send_byte(hcbd_pkg::CH_LF);
				send_byte(hcbd_pkg::CH_CR);
				send_byte(hcbd_pkg::CH_LF);
			end
			END_BODY_OVER: begin
				// one byte over the body limit, caught on the closing lf
				write_reg(hcbd_pkg::REG_MAX_BODY, 32'(body_total + len - 1));
				send_chunk(len);
			end
			END_CHUNK_OVER: begin
				// size one above the chunk limit, zero limit half the time
				lim = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
				write_reg(hcbd_pkg::REG_MAX_CHUNK, {8'($urandom), 24'(lim)});
				send_hex(24'(lim + 1), 0);
				send_byte(hcbd_pkg::CH_CR);
			end
			END_HUGE: begin
				// enough digits to saturate the size accumulator
				write_reg(hcbd_pkg::REG_MAX_CHUNK, 32'h00FF_FFFF);
				send_byte(hex_char(4'($urandom_range(2, 15))));
				repeat ($urandom_range(6, 10)) send_byte(hex_char(4'($urandom)));
				send_byte(hcbd_pkg::CH_CR);
			end
			END_BAD_DIGIT: begin
				if ($urandom_range(0, 1))
					send_hex(24'(len), 0);
				// neighbors of the hex ranges, space, extension semicolon
				case ($urandom_range(0, 10))
					0: b = 8'h00;
					1: b = 8'hFF;
					2: b = hcbd_pkg::CH_LF;
					3: b = 8'h20;
					4: b = 8'h3B;
					5: b = 8'h2F;
					6: b = 8'h3A;
					7: b = 8'h40;
					8: b = 8'h47;
					9: b = 8'h60;
					default: b = 8'h67;
				endcase
				send_byte(b);
			end
			END_NO_LF_SIZE: begin
				send_hex(24'(len), 0);
				send_byte(hcbd_pkg::CH_CR);
				b = 8'($urandom);
				if (b == hcbd_pkg::CH_LF)
					b = hcbd_pkg::CH_CR;
				send_byte(b);
			end
			END_NO_LF_BODY: begin
				send_head(len);
				send_payload(len);
				send_byte(hcbd_pkg::CH_CR);
				b = 8'($urandom);
				if (b == hcbd_pkg::CH_LF)
					b = hcbd_pkg::CH_CR;
				send_byte(b);
			end
			default: begin
				// payload count used up but no cr follows
				send_head(len);
				send_payload(len);
				b = 8'($urandom);
				if (b == hcbd_pkg::CH_CR)
					b = hcbd_pkg::CH_LF;
				send_byte(b);
			end
		endcase

		// bytes after the end or the error must be ignored
		repeat (12) send_byte(8'($urandom));
		settle();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("http_chunked_body_decoder_unit: match");
		else
			$display("http_chunked_body_decoder_unit: mismatch");
		$finish;
	end

endmodule
